### src/assert_macros.svh
// Assertion helpers for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hss: same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hss: next-cycle assertion failed");

`endif

### src/hss_pkg.sv
package hss_pkg;

  // Width of the internal position counter; it wraps at this width.
  localparam int POSITION_BITS = 24;

  // Fixed field widths of the channels.
  localparam int COUNT_W   = 24;
  localparam int TARGET_W  = 24;
  localparam int OUT_POS_W = 24;
  localparam int COIL_W    = 4;

  localparam int HALF_STEPS = 8;
  localparam int INDEX_W    = $clog2(HALF_STEPS);

  // Width that holds both the target and the position without loss.
  localparam int POS_EXT_W = (POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W;
  localparam int DIFF_W    = POS_EXT_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COIL_W-1:0]  COILS_OFF = '0;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_GOTO  = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic [COUNT_W-1:0]         step_count;
    logic signed [TARGET_W-1:0] target_position;
  } hss_item_t;

  typedef struct packed {
    logic [COIL_W-1:0]           coil_pattern;
    logic                        busy_res;
    logic signed [OUT_POS_W-1:0] position;
    logic                        move_done;
  } hss_result_t;

  // Half-step coil patterns, bits A0,A1,B0,B1 from bit 0 upward.
  function automatic logic [COIL_W-1:0] coil_lookup(input logic turn_right,
                                                    input logic [INDEX_W-1:0] idx);
    logic [COIL_W-1:0] pattern;
    if (turn_right) begin
      case (idx)
        3'd0:    pattern = 4'd5;
        3'd1:    pattern = 4'd1;
        3'd2:    pattern = 4'd9;
        3'd3:    pattern = 4'd8;
        3'd4:    pattern = 4'd10;
        3'd5:    pattern = 4'd2;
        3'd6:    pattern = 4'd6;
        3'd7:    pattern = 4'd4;
        default: pattern = COILS_OFF;
      endcase
    end else begin
      case (idx)
        3'd0:    pattern = 4'd5;
        3'd1:    pattern = 4'd4;
        3'd2:    pattern = 4'd6;
        3'd3:    pattern = 4'd2;
        3'd4:    pattern = 4'd10;
        3'd5:    pattern = 4'd8;
        3'd6:    pattern = 4'd9;
        3'd7:    pattern = 4'd1;
        default: pattern = COILS_OFF;
      endcase
    end
    return pattern;
  endfunction

endpackage

### src/hss_cmd_if.sv
interface hss_cmd_if import hss_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [COUNT_W-1:0]         step_count;
  logic signed [TARGET_W-1:0] target_position;

  modport source (output valid, output opcode, output step_count,
                  output target_position, input ready);
  modport sink   (input valid, input opcode, input step_count,
                  input target_position, output ready);
endinterface

### src/hss_res_if.sv
interface hss_res_if import hss_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [COIL_W-1:0]           coil_pattern;
  logic                        busy_res;
  logic signed [OUT_POS_W-1:0] position;
  logic                        move_done;

  modport source (output valid, output coil_pattern, output busy_res,
                  output position, output move_done, input ready);
  modport sink   (input valid, input coil_pattern, input busy_res,
                  input position, input move_done, output ready);
endinterface

### src/hss_in_stage.sv
module hss_in_stage import hss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hss_cmd_if.sink     cmd_i,
  input  logic        advance_i,
  output logic        item_valid_o,
  output hss_item_t   item_o
);

  logic      full_q, full_d;
  hss_item_t item_q;
  logic      take;

  // A new transaction is taken when the register is empty or drains this cycle.
  assign cmd_i.ready = !full_q || advance_i;
  assign take        = cmd_i.valid && cmd_i.ready;

  always_comb begin
    full_d = full_q;
    if (take) begin
      full_d = 1'b1;
    end else if (advance_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.opcode          <= opcode_e'(cmd_i.opcode);
      item_q.step_count      <= cmd_i.step_count;
      item_q.target_position <= cmd_i.target_position;
    end
  end

  assign item_valid_o = full_q;
  assign item_o       = item_q;

endmodule

### src/hss_core.sv
module hss_core import hss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  hss_item_t   item_i,
  output hss_result_t result_o
);

  logic                     busy_q, busy_d;
  logic                     right_q, right_d;
  logic [COUNT_W-1:0]       taken_q, taken_d;
  logic [COUNT_W-1:0]       wanted_q, wanted_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [COIL_W-1:0]        coil_q, coil_d;
  logic                     done;

  logic signed [POS_EXT_W-1:0] pos_ext;
  logic signed [POS_EXT_W-1:0] pos_ext_d;
  logic signed [DIFF_W-1:0]    diff;
  logic [DIFF_W-1:0]           goto_dist;
  logic [COUNT_W-1:0]          goto_count;
  logic                        goto_right;

  // Distance to the go-to target, saturated to the step counter range.
  assign pos_ext    = POS_EXT_W'(signed'(pos_q));
  assign diff       = DIFF_W'(item_i.target_position) - DIFF_W'(pos_ext);
  assign goto_right = !diff[DIFF_W-1];
  assign goto_dist  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign goto_count = (goto_dist > DIFF_W'(COUNT_MAX)) ? COUNT_MAX
                                                       : goto_dist[COUNT_W-1:0];

  // Next state for one transaction.
  always_comb begin
    busy_d   = busy_q;
    right_d  = right_q;
    taken_d  = taken_q;
    wanted_d = wanted_q;
    pos_d    = pos_q;
    coil_d   = coil_q;
    done     = 1'b0;
    case (item_i.opcode)
      OP_TICK: begin
        if (busy_q) begin
          if (taken_q < wanted_q) begin
            coil_d  = coil_lookup(right_q, taken_q[INDEX_W-1:0]);
            pos_d   = right_q ? pos_q + 1'b1 : pos_q - 1'b1;
            taken_d = taken_q + 1'b1;
          end else begin
            coil_d  = COILS_OFF;
            busy_d  = 1'b0;
            taken_d = '0;
            done    = 1'b1;
          end
        end
      end
      OP_LEFT, OP_RIGHT: begin
        if (!busy_q) begin
          busy_d   = 1'b1;
          right_d  = (item_i.opcode == OP_RIGHT);
          taken_d  = '0;
          wanted_d = item_i.step_count;
        end
      end
      OP_GOTO: begin
        if (!busy_q && (diff != '0)) begin
          busy_d   = 1'b1;
          right_d  = goto_right;
          taken_d  = '0;
          wanted_d = goto_count;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      right_q  <= 1'b0;
      taken_q  <= '0;
      wanted_q <= '0;
      pos_q    <= '0;
      coil_q   <= COILS_OFF;
    end else if (advance_i) begin
      busy_q   <= busy_d;
      right_q  <= right_d;
      taken_q  <= taken_d;
      wanted_q <= wanted_d;
      pos_q    <= pos_d;
      coil_q   <= coil_d;
    end
  end

  // The result shows the state after this transaction.
  assign pos_ext_d             = POS_EXT_W'(signed'(pos_d));
  assign result_o.coil_pattern = coil_d;
  assign result_o.busy_res     = busy_d;
  assign result_o.position     = pos_ext_d[OUT_POS_W-1:0];
  assign result_o.move_done    = done;

endmodule

### src/stepper_half_step_sequencer.sv
// Half-step stepper sequencer.
// The cmd_i channel takes commands and ticks: opcode 0 is a tick, 1 and 2
// start a left or right move of step_count half steps, 3 moves to
// target_position. Commands are ignored while a move runs.
// Every accepted transaction yields exactly one result on res_o: the coil
// pattern, the busy flag, the signed position and a done flag on the tick
// that ends a move.
// An accepted transaction waits in the input register, and its result is
// loaded into the result register when that register is free. Throughput is
// one transaction per cycle while res_o does not stall; the state update
// between the two registers is combinational.
// When res_o stalls, the result register holds its value, the input register
// holds one more transaction, and then cmd_i.ready drops until the result is
// taken.
// Reset clears the position to zero, switches all coils off and leaves the
// block idle with both registers empty.
`include "assert_macros.svh"

module stepper_half_step_sequencer import hss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  hss_cmd_if.sink  cmd_i,
  hss_res_if.source res_o
);

  logic        item_valid;
  hss_item_t   item;
  hss_result_t result;
  hss_result_t res_q;
  logic        res_valid_q, res_valid_d;
  logic        advance;
  logic        res_done;
  logic        res_idle;
  logic        res_stalled;

  // Move the held transaction on when the result register is free.
  assign advance = item_valid && (!res_valid_q || res_o.ready);

  hss_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  hss_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  // Result register valid flag.
  always_comb begin
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.coil_pattern = res_q.coil_pattern;
  assign res_o.busy_res     = res_q.busy_res;
  assign res_o.position     = res_q.position;
  assign res_o.move_done    = res_q.move_done;

  // Terms used by the checks below.
  assign res_done    = res_valid_q && res_q.move_done;
  assign res_idle    = !res_q.busy_res && (res_q.coil_pattern == COILS_OFF);
  assign res_stalled = item_valid && res_valid_q && !res_o.ready;

  // A finished move leaves the coils off and the block idle.
  `HSS_ASSERT_IMPLY(a_done_idle, clk_i, rst_ni, res_done, res_idle)

  // Both registers full with the output stalled blocks new transactions.
  `HSS_ASSERT_IMPLY(a_full_stall, clk_i, rst_ni, res_stalled, !cmd_i.ready)

  // An accepted transaction is held in the input register next cycle.
  `HSS_ASSERT_NEXT(a_take_held, clk_i, rst_ni, cmd_i.valid && cmd_i.ready, item_valid)

endmodule
